[hdl/fpsd_pkg.sv]
// Package: types and constants for the feature position/scale duplicate filter.
`default_nettype none
package fpsd_pkg;

    localparam int unsigned ROW_W   = 20;
    localparam int unsigned COL_W   = 20;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned STEP_W  = 11;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned ENTRY_W = ROW_W + COL_W + SCALE_W;

    localparam logic [STEP_W-1:0]  STEP_RESET = 11'd358;
    // 3 px in 1/256 px units: twice the 1.5 px radius floor
    localparam logic [SCALE_W-1:0] LIM_FLOOR  = 16'd768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fpsd_state_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } fpsd_entry_t;

endpackage
`default_nettype wire

[hdl/feature_position_scale_dedup_top.sv]
// Top level: greedy duplicate suppression of features against a memory of kept entries.
//
//  channel   dir  fields (lsb first)
//  s_        in   tuser: first_of_set; tdata: row_pos, col_pos, feature_scale
//  m_        out  tdata: keep, table_full, kept_count, zero pad
//  cfg_      in   cfg_wdata: scale_step
//
// An item passes through accept, one memory read per kept entry, the drain of the compare
// pipeline, a check that it is empty and the write-back. The scan stops issuing reads once
// a duplicate is seen. Write-back waits while an unaccepted word sits in the output
// register; the next word is taken while a result waits there.
// Synchronous active-low reset empties the table; no clearing pass.
`default_nettype none
module feature_position_scale_dedup_top #(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [55:0] s_tdata,   // row_pos[19:0], col_pos[39:20], feature_scale[55:40]
    input  wire logic [0:0]  s_tuser,   // first_of_set
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // keep[0], table_full[1], kept_count[10:2], zero
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata  // scale_step
);

    localparam int unsigned ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CLOG_N = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CNT_W  = (CLOG_N > fpsd_pkg::COUNT_W) ? CLOG_N
                                                                  : fpsd_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    fpsd_pkg::fpsd_state_t state_reg, state_next;

    logic [fpsd_pkg::STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    fpsd_pkg::fpsd_entry_t       item_reg;
    logic                        dup_reg, dup_next;

    fpsd_pkg::fpsd_entry_t       mem [MAX_ENTRIES];
    fpsd_pkg::fpsd_entry_t       rdata_reg;
    logic                        rd_en, wr_en;

    logic                        v1_reg, v2_reg, v3_reg;
    logic [fpsd_pkg::ROW_W-1:0]  dr_reg;
    logic [fpsd_pkg::COL_W-1:0]  dc_reg;
    logic [fpsd_pkg::SCALE_W-1:0] smin_reg, smax_reg, smax3_reg;
    logic [2*fpsd_pkg::ROW_W-1:0] dr2_reg;
    logic [2*fpsd_pkg::COL_W-1:0] dc2_reg;
    logic [2*fpsd_pkg::SCALE_W-1:0] lim2_reg;
    logic [fpsd_pkg::STEP_W+fpsd_pkg::SCALE_W-1:0] sim_rhs_reg;

    logic [fpsd_pkg::ROW_W-1:0]   dr;
    logic [fpsd_pkg::COL_W-1:0]   dc;
    logic [fpsd_pkg::SCALE_W-1:0] smin, smax, lim;
    logic [2*fpsd_pkg::ROW_W:0]   dsum;
    logic [2*fpsd_pkg::ROW_W+2:0] d4;
    logic                         near, similar, hit;

    logic                         keep, full, load_out;
    logic                         m_tvalid_reg;
    logic                         out_keep_reg, out_full_reg;
    logic [fpsd_pkg::COUNT_W-1:0] out_count_reg;

    assign s_tready = (state_reg == fpsd_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_count_reg, out_full_reg, out_keep_reg};

    // scale ratio limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= fpsd_pkg::STEP_RESET;
        end else if (cfg_we) begin
            step_reg <= cfg_wdata;
        end
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // compare pipeline
    always_comb begin
        dr   = (item_reg.row > rdata_reg.row) ? item_reg.row - rdata_reg.row
                                              : rdata_reg.row - item_reg.row;
        dc   = (item_reg.col > rdata_reg.col) ? item_reg.col - rdata_reg.col
                                              : rdata_reg.col - item_reg.col;
        smin = (item_reg.scale < rdata_reg.scale) ? item_reg.scale : rdata_reg.scale;
        smax = (item_reg.scale < rdata_reg.scale) ? rdata_reg.scale : item_reg.scale;
        lim  = (smin_reg > fpsd_pkg::LIM_FLOOR) ? smin_reg : fpsd_pkg::LIM_FLOOR;
        dsum = {1'b0, dr2_reg} + {1'b0, dc2_reg};
        d4   = {dsum, 2'b00};
        near    = d4 < {11'd0, lim2_reg};
        similar = {3'd0, smax3_reg, 8'd0} < sim_rhs_reg;
        hit     = v3_reg && near && similar;
    end

    always_ff @(posedge aclk) begin
        dr_reg      <= dr;
        dc_reg      <= dc;
        smin_reg    <= smin;
        smax_reg    <= smax;
        lim2_reg    <= lim * lim;
        dr2_reg     <= dr_reg * dr_reg;
        dc2_reg     <= dc_reg * dc_reg;
        sim_rhs_reg <= step_reg * smin_reg;
        smax3_reg   <= smax_reg;
    end

    // lim2 is squared from the second stage, so it lines up with dr2/dc2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpsd_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            dup_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            dup_reg   <= dup_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= fpsd_pkg::fpsd_entry_t'(s_tdata);
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        dup_next   = dup_reg || hit;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        keep       = !dup_reg;
        full       = !dup_reg && (count_reg == MAX_CNT);
        unique case (state_reg)
            fpsd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next   = '0;
                    dup_next   = 1'b0;
                    state_next = fpsd_pkg::ST_SCAN;
                    if (s_tuser[0]) begin
                        count_next = '0;
                    end
                end
            end
            fpsd_pkg::ST_SCAN: begin
                rd_en = (idx_reg < count_reg) && !dup_reg;
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!v1_reg && !v2_reg && !v3_reg) begin
                    state_next = fpsd_pkg::ST_DONE;
                end
            end
            fpsd_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = fpsd_pkg::ST_IDLE;
                    if (keep && !full) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = fpsd_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_keep_reg  <= keep;
            out_full_reg  <= full;
            out_count_reg <= count_next[fpsd_pkg::COUNT_W-1:0];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("entry count beyond table size");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg < MAX_CNT) && !dup_reg)
        else $error("table write without room or for a duplicate");

    a_full_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
        else $error("table_full flagged on a duplicate");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("entry count did not advance on store");

    a_no_read_out: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (state_reg == fpsd_pkg::ST_SCAN) && (idx_reg < count_reg))
        else $error("table read outside scan or beyond count");

endmodule
`default_nettype wire

[tb/fpsd_dedup_checker.sv]
// Checker for the feature duplicate filter: tracks the kept table, predicts each result word and compares.
module fpsd_dedup_checker #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,   // row_pos[19:0], col_pos[39:20], feature_scale[55:40]
    input  wire logic [0:0]  s_tuser,   // first_of_set
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // keep[0], table_full[1], kept_count[10:2], zero
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata, // scale_step
    output int               errors,
    output int               pending,
    output int               kept_seen,
    output int               dups_seen,
    output int               full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]                   pad;
        logic [fpsd_pkg::COUNT_W-1:0] kept_count;
        logic                         table_full;
        logic                         keep;
    } verdict_t;

    fpsd_pkg::fpsd_entry_t       kept_tab [DEPTH];
    int unsigned                 kept_n;
    logic [fpsd_pkg::STEP_W-1:0] ratio_limit;
    verdict_t                    verdict_q [$];
    int                          err_n;
    int                          kept_total;
    int                          dup_total;
    int                          full_total;

    // Greedy scan: first kept entry that is both close enough and of similar scale wins.
    function automatic verdict_t judge_feature(input logic first,
                                               input fpsd_pkg::fpsd_entry_t f);
        verdict_t              v;
        logic                  dup;
        logic                  near;
        logic                  similar;
        fpsd_pkg::fpsd_entry_t k;
        logic [63:0]           dr, dc, smin, smax, lim;
        v   = '0;
        dup = 1'b0;
        if (first) begin
            kept_n = 0;
        end
        for (int i = 0; i < int'(kept_n) && !dup; i++) begin
            k       = kept_tab[i];
            dr      = (f.row > k.row) ? f.row - k.row : k.row - f.row;
            dc      = (f.col > k.col) ? f.col - k.col : k.col - f.col;
            smin    = (f.scale < k.scale) ? f.scale : k.scale;
            smax    = (f.scale < k.scale) ? k.scale : f.scale;
            lim     = (smin > fpsd_pkg::LIM_FLOOR) ? smin : fpsd_pkg::LIM_FLOOR;
            near    = (64'd4 * (dr * dr + dc * dc)) < (lim * lim);
            similar = (smax * 64'd256) < (ratio_limit * smin);
            dup     = near && similar;
        end
        if (!dup) begin
            if (kept_n < DEPTH) begin
                kept_tab[kept_n] = f;
                kept_n++;
            end else begin
                v.table_full = 1'b1;
            end
        end
        v.keep       = !dup;
        v.kept_count = fpsd_pkg::COUNT_W'(kept_n);
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (!aresetn) begin
            verdict_q.delete();
            kept_n      = 0;
            ratio_limit = fpsd_pkg::STEP_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata);
                if (verdict_q.size() == 0) begin
                    $error("result word %h with no feature outstanding", m_tdata);
                    err_n++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.keep !== want.keep) begin
                        $error("keep: expected %0d, got %0d", want.keep, got.keep);
                        err_n++;
                    end
                    if (got.table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, got.table_full);
                        err_n++;
                    end
                    if (got.kept_count !== want.kept_count) begin
                        $error("kept_count: expected %0d, got %0d",
                               want.kept_count, got.kept_count);
                        err_n++;
                    end
                    if (got.pad !== want.pad) begin
                        $error("pad: expected %0d, got %0d", want.pad, got.pad);
                        err_n++;
                    end
                end
            end
            if (cfg_we) begin
                ratio_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                want = judge_feature(s_tuser[0], fpsd_pkg::fpsd_entry_t'(s_tdata));
                verdict_q = {verdict_q, want};
                if (!want.keep) begin
                    dup_total++;
                end else if (want.table_full) begin
                    full_total++;
                end else begin
                    kept_total++;
                end
            end
        end
        pending   <= verdict_q.size();
        errors    <= err_n;
        kept_seen <= kept_total;
        dups_seen <= dup_total;
        full_seen <= full_total;
    end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, feature stimulus and scale_step settings for the duplicate filter.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  TABLE_DEPTH  = 256;
    localparam int           PHASE_ITEMS  = 255;
    localparam int           FILL_ITEMS   = 300;
    localparam int           QUIET_LIMIT  = 5000;
    localparam logic [10:0]  STEP_LO      = 11'd257;
    localparam logic [10:0]  STEP_HI      = 11'd1024;
    localparam logic [10:0]  STEP_NEVER   = 11'd256;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = fpsd_pkg::STEP_RESET;

    int errors, pending, kept_seen, dups_seen, full_seen;
    int items_sent;
    int step_writes;
    int quiet_cycles;
    bit steady;

    feature_position_scale_dedup_top #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    fpsd_dedup_checker #(
        .DEPTH(TABLE_DEPTH)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .errors   (errors),
        .pending  (pending),
        .kept_seen(kept_seen),
        .dups_seen(dups_seen),
        .full_seen(full_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            quiet_cycles++;
        end else begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic fpsd_pkg::fpsd_entry_t feature(input logic [31:0] r, c, s);
        return {s[15:0], c[19:0], r[19:0]};
    endfunction

    // Jitters position within about the suppression radius and scale by 0.6x to 1.6x.
    function automatic fpsd_pkg::fpsd_entry_t near_copy(input fpsd_pkg::fpsd_entry_t b);
        int rad, rr, cc, ss;
        rad = ((b.scale > fpsd_pkg::LIM_FLOOR) ? int'(b.scale)
                                               : int'(fpsd_pkg::LIM_FLOOR)) / 2 + 32;
        rr  = int'(b.row) + int'($urandom_range(2 * rad)) - rad;
        cc  = int'(b.col) + int'($urandom_range(2 * rad)) - rad;
        ss  = int'(b.scale) * int'($urandom_range(160, 420)) / 256;
        rr  = (rr < 0) ? 0 : (rr > 20'hFFFFF) ? 20'hFFFFF : rr;
        cc  = (cc < 0) ? 0 : (cc > 20'hFFFFF) ? 20'hFFFFF : cc;
        ss  = (ss < 1) ? 1 : (ss > 16'hFFFF) ? 16'hFFFF : ss;
        return feature(rr, cc, ss);
    endfunction

    task automatic send_feature(input logic first, input fpsd_pkg::fpsd_entry_t f);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 30) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_step(input logic [10:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        step_writes++;
    endtask

    initial begin
        fpsd_pkg::fpsd_entry_t f;
        fpsd_pkg::fpsd_entry_t hist [$];
        int          left, len, pick;
        int          base_r, base_c;
        logic        first;
        logic [10:0] step;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: radius and ratio edges, zero scale, set restart, field extremes
        apply_step(fpsd_pkg::STEP_RESET);
        send_feature(1'b1, feature(0, 0, 256));
        send_feature(1'b0, feature(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
        send_feature(1'b0, feature(20'hFFF9B, 20'hFFFFF, 16'hFFFF));
        send_feature(1'b0, feature(383, 0, 256));
        send_feature(1'b0, feature(0, 384, 256));
        send_feature(1'b0, feature(271, 271, 256));
        send_feature(1'b0, feature(0, 0, 0));
        send_feature(1'b0, feature(0, 0, 0));
        send_feature(1'b0, feature(0, 0, 356));
        send_feature(1'b0, feature(0, 0, 358));
        send_feature(1'b1, feature(0, 0, 256));
        send_feature(1'b0, feature(0, 0, 256));
        send_feature(1'b0, feature(0, 0, 1));
        send_feature(1'b1, feature(20'hAAAAA, 20'h55555, 16'h5555));
        send_feature(1'b0, feature(20'h55555, 20'hAAAAA, 16'hAAAA));
        apply_step(STEP_NEVER);
        send_feature(1'b1, feature(1000, 1000, 500));
        send_feature(1'b0, feature(1000, 1000, 500));
        apply_step(STEP_HI);
        send_feature(1'b1, feature(0, 0, 256));
        send_feature(1'b0, feature(0, 0, 1020));
        send_feature(1'b0, feature(0, 0, 1024));
        apply_step(STEP_LO);
        send_feature(1'b1, feature(5000, 5000, 300));
        send_feature(1'b0, feature(5000, 5000, 300));

        for (int p = 0; p < 6; p++) begin
            step = (p == 0 || p == 5) ? fpsd_pkg::STEP_RESET : (p == 1) ? STEP_HI :
                   (p == 2) ? STEP_LO : 11'($urandom_range(STEP_LO, STEP_HI));
            apply_step(step);
            steady = (p == 3);
            left   = PHASE_ITEMS;
            if (p == 0) begin
                // spread features until the table overflows, then revisit some
                hist.delete();
                for (int i = 0; i < FILL_ITEMS; i++) begin
                    if (i < 280) begin
                        f = feature(i * 1024 + $urandom_range(127),
                                    $urandom_range(20'hFFFFF), $urandom_range(1, 700));
                        hist = {hist, f};
                    end else begin
                        f = near_copy(hist[$urandom_range(hist.size() - 1)]);
                    end
                    send_feature(i == 0, f);
                end
                left -= FILL_ITEMS;
            end
            while (left > 0) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
                if (len > left) begin
                    len = left;
                end
                hist.delete();
                base_r = $urandom_range(20'hFFFFF - 8192);
                base_c = $urandom_range(20'hFFFFF - 8192);
                for (int i = 0; i < len; i++) begin
                    first = (i == 0) || ($urandom_range(49) == 0);
                    if (first) begin
                        hist.delete();
                    end
                    pick = $urandom_range(99);
                    if (pick < 45 && hist.size() > 0) begin
                        f = near_copy(hist[$urandom_range(hist.size() - 1)]);
                    end else if (pick < 80) begin
                        f = feature(base_r + $urandom_range(4096), base_c + $urandom_range(4096),
                                    $urandom_range(64, 3000));
                    end else begin
                        f = feature($urandom, $urandom, $urandom_range(1, 16'hFFFF));
                    end
                    hist = {hist, f};
                    send_feature(first, f);
                end
                left -= len;
            end
        end
        steady = 1'b0;
        drain();

        $display("Run covered %0d features across %0d scale_step writes.", items_sent, step_writes);
        $display("Outcomes: %0d stored, %0d suppressed as duplicates, %0d refused on a full table.",
                 kept_seen, dups_seen, full_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/fpsd_pkg.sv
hdl/feature_position_scale_dedup_top.sv
tb/fpsd_dedup_checker.sv
tb/testbench.sv
